// ===== rtl/nrbf_pkg.sv =====
// Shared types and constants for the normalized RBF evaluator.
package nrbf_pkg;

    localparam int NUM_CENTERS = 8;
    localparam int IDX_W       = $clog2(NUM_CENTERS);
    localparam int NUM_W       = 34 + $clog2(NUM_CENTERS);
    localparam int DEN_W       = 17 + $clog2(NUM_CENTERS);

    localparam int DIV_NW = 52;
    localparam int DIV_DW = 33;
    localparam int DIV_QW = 32;

    localparam logic [1:0] OP_LOAD_CENTER = 2'd0;
    localparam logic [1:0] OP_LOAD_WEIGHT = 2'd1;
    localparam logic [1:0] OP_EVAL        = 2'd2;

    localparam logic [2:0] STS_OK        = 3'd0;
    localparam logic [2:0] STS_SAT       = 3'd1;
    localparam logic [2:0] STS_NO_WEIGHT = 3'd2;
    localparam logic [2:0] STS_EQ_CENTER = 3'd3;
    localparam logic [2:0] STS_ZERO_SUM  = 3'd4;

    localparam logic [15:0] L_RESET     = 16'd2839;
    localparam logic [30:0] ONE_Q30     = 31'd1073741824;
    localparam logic [28:0] EXP_M1_Q30  = 29'd395007543;
    localparam logic [3:0]  TAYLOR_LAST = 4'd13;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_ACCEPT,
        DP_ERR,
        DP_INIT,
        DP_RD_CJ,
        DP_D2,
        DP_DX2,
        DP_MUL_L,
        DP_DIVE_GO,
        DP_DIVE_WAIT,
        DP_TMUL,
        DP_TDIV_GO,
        DP_TDIV_WAIT,
        DP_EMUL,
        DP_PHI,
        DP_WMUL,
        DP_ACC,
        DP_ABSMUL,
        DP_FDIV_GO,
        DP_FDIV_WAIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [2:0] code;
    } dp_cmd_t;

    typedef struct packed {
        logic mask_full;
        logic eq_centers;
        logic div_done;
        logic e_big;
        logic k_last;
        logic n_done;
        logic i_last;
        logic den_zero;
    } dp_stat_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CHECK,
        S_RD_CJ,
        S_D2,
        S_DX2,
        S_MUL_L,
        S_DIVE_GO,
        S_DIVE_WAIT,
        S_TMUL,
        S_TDIV_GO,
        S_TDIV_WAIT,
        S_EMUL,
        S_PHI,
        S_WMUL,
        S_ACC,
        S_FIN,
        S_ABSMUL,
        S_FDIV_GO,
        S_FDIV_WAIT,
        S_DONE
    } ctrl_state_t;

endpackage

// ===== rtl/normalized_rbf_evaluator_core.sv =====
// Top level of the normalized Gaussian RBF evaluator.
// Load beats give no result; busy stays low. Evaluate: per center, divide for the
// exponent, run the Taylor series, then n multiplies by e^-1, n = integer part of
// the exponent (0..15); a center whose exponent reaches 16 skips the last two.
// Missing weights or equal centers end at the check. The divider is shared.
// done pulses one cycle with the result; the receiver cannot stall.
module normalized_rbf_evaluator_core
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         op,
    input  logic [2:0]         entry_index,
    input  logic signed [15:0] operand_value,
    input  logic               cfg_we,
    input  logic [15:0]        cfg_wdata,
    output logic               done,
    output logic signed [15:0] approx_value,
    output logic [2:0]         status
);

    nrbf_pkg::dp_cmd_t  cmd;
    nrbf_pkg::dp_stat_t stat;

    nrbf_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .op    (op),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    nrbf_datapath u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .op            (op),
        .entry_index   (entry_index),
        .operand_value (operand_value),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .stat          (stat),
        .approx_value  (approx_value),
        .status        (status)
    );

endmodule

// ===== rtl/nrbf_div.sv =====
// Shared restoring divider, one quotient bit per cycle, with overflow flag.
module nrbf_div
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [nrbf_pkg::DIV_NW-1:0] num,
    input  logic [nrbf_pkg::DIV_DW-1:0] den,
    output logic                         done,
    output logic                         ovf,
    output logic [nrbf_pkg::DIV_QW-1:0] quot
);

    localparam int CNT_W = $clog2(nrbf_pkg::DIV_QW + 1);
    localparam int HI_W  = nrbf_pkg::DIV_NW - nrbf_pkg::DIV_QW;

    logic                         active_reg, active_next;
    logic                         done_reg, done_next;
    logic                         ovf_reg, ovf_next;
    logic [CNT_W-1:0]             cnt_reg, cnt_next;
    logic [nrbf_pkg::DIV_DW-1:0] rem_reg, rem_next;
    logic [nrbf_pkg::DIV_DW-1:0] den_reg, den_next;
    logic [nrbf_pkg::DIV_QW-1:0] q_reg, q_next;
    logic [nrbf_pkg::DIV_DW:0]   rem2;
    logic                         ge;

    assign rem2 = {rem_reg, q_reg[nrbf_pkg::DIV_QW-1]};
    assign ge   = (rem2 >= {1'b0, den_reg});

    always_comb
    begin
        active_next = active_reg;
        done_next   = 1'b0;
        ovf_next    = ovf_reg;
        cnt_next    = cnt_reg;
        rem_next    = rem_reg;
        den_next    = den_reg;
        q_next      = q_reg;
        if (start)
        begin
            active_next = 1'b1;
            ovf_next    = ({{(nrbf_pkg::DIV_DW-HI_W){1'b0}},
                            num[nrbf_pkg::DIV_NW-1:nrbf_pkg::DIV_QW]} >= den);
            cnt_next    = CNT_W'(nrbf_pkg::DIV_QW);
            rem_next    = nrbf_pkg::DIV_DW'(num[nrbf_pkg::DIV_NW-1:nrbf_pkg::DIV_QW]);
            den_next    = den;
            q_next      = num[nrbf_pkg::DIV_QW-1:0];
        end
        else if (active_reg)
        begin
            rem_next = ge ? nrbf_pkg::DIV_DW'(rem2 - {1'b0, den_reg})
                          : rem2[nrbf_pkg::DIV_DW-1:0];
            q_next   = {q_reg[nrbf_pkg::DIV_QW-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            done_reg   <= done_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ovf_reg <= ovf_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        q_reg   <= q_next;
    end

    assign done = done_reg;
    assign ovf  = ovf_reg;
    assign quot = q_reg;

endmodule

// ===== rtl/nrbf_datapath.sv =====
// Datapath: tables, exponent, Taylor series, accumulation and final scaling.
module nrbf_datapath
(
    input  logic                clk,
    input  logic                rst_n,
    input  nrbf_pkg::dp_cmd_t  cmd,
    input  logic [1:0]          op,
    input  logic [2:0]          entry_index,
    input  logic signed [15:0]  operand_value,
    input  logic                cfg_we,
    input  logic [15:0]         cfg_wdata,
    output nrbf_pkg::dp_stat_t stat,
    output logic signed [15:0]  approx_value,
    output logic [2:0]          status
);

    localparam int N = nrbf_pkg::NUM_CENTERS;
    localparam int IW = nrbf_pkg::IDX_W;
    localparam logic [28:0] EXP_M1 = nrbf_pkg::EXP_M1_Q30;

    logic signed [15:0] ctr_reg [N];
    logic signed [15:0] wt_reg  [N];
    logic [N-1:0]       mask_reg;
    logic [15:0]        l_reg;
    logic signed [15:0] x_reg;
    logic signed [15:0] cj_reg;
    logic [31:0]        d2_reg;
    logic [31:0]        dx2_reg;
    logic [47:0]        en_reg;
    logic [15:0]        f_reg;
    logic [3:0]         n_reg;
    logic [3:0]         cnt_reg;
    logic [3:0]         k_reg;
    logic [30:0]        term_reg;
    logic [30:0]        sum_reg;
    logic [46:0]        tf_reg;
    logic [16:0]        phi_reg;
    logic signed [32:0] pw_reg;
    logic signed [nrbf_pkg::NUM_W-1:0] num_reg;
    logic [nrbf_pkg::DEN_W-1:0]        den_reg;
    logic [50:0]        p_reg;
    logic [IW-1:0]      i_reg;
    logic signed [15:0] res_val_reg;
    logic [2:0]         res_sts_reg;

    logic [IW-1:0]      j_idx;
    logic [IW-1:0]      rd_addr;
    logic signed [15:0] rd_c;
    logic signed [16:0] diff;
    logic signed [33:0] sq;
    logic               eq_any;
    logic                         div_start;
    logic [nrbf_pkg::DIV_NW-1:0] div_num;
    logic [nrbf_pkg::DIV_DW-1:0] div_den;
    logic                         div_done;
    logic                         div_ovf;
    logic [nrbf_pkg::DIV_QW-1:0] div_q;
    logic               e_big;
    logic [59:0]        emul;
    logic [30:0]        phi_sum;
    logic [15:0]        x_abs;
    logic signed [nrbf_pkg::NUM_W-1:0] num_neg;
    logic [34:0]        num_abs;
    logic [16:0]        r17;
    logic [16:0]        r17_neg;
    logic               res_neg;
    logic signed [15:0] y_val;
    logic [2:0]         y_sts;

    nrbf_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .ovf   (div_ovf),
        .quot  (div_q)
    );

    assign j_idx = (i_reg == IW'(N - 1)) ? IW'(N - 2) : i_reg;

    always_comb
    begin
        unique case (cmd.op)
            nrbf_pkg::DP_RD_CJ: rd_addr = j_idx;
            nrbf_pkg::DP_D2:    rd_addr = j_idx + 1'b1;
            default:            rd_addr = i_reg;
        endcase
    end

    assign rd_c = ctr_reg[rd_addr];
    assign diff = (cmd.op == nrbf_pkg::DP_D2)
                ? ({rd_c[15], rd_c} - {cj_reg[15], cj_reg})
                : ({x_reg[15], x_reg} - {rd_c[15], rd_c});
    assign sq   = diff * diff;

    always_comb
    begin
        eq_any = 1'b0;
        for (int m = 1; m < N; m++)
        begin
            if (ctr_reg[m] == ctr_reg[m-1])
                eq_any = 1'b1;
        end
    end

    assign e_big = div_ovf || (div_q[31:20] != 12'd0);

    always_comb
    begin
        div_start = 1'b0;
        div_num   = {en_reg, 4'b0};
        div_den   = {1'b0, d2_reg};
        unique case (cmd.op)
            nrbf_pkg::DP_DIVE_GO:
            begin
                div_start = 1'b1;
            end
            nrbf_pkg::DP_TDIV_GO:
            begin
                div_start = 1'b1;
                div_num   = nrbf_pkg::DIV_NW'(tf_reg[46:16]);
                div_den   = nrbf_pkg::DIV_DW'(k_reg);
            end
            nrbf_pkg::DP_FDIV_GO:
            begin
                div_start = 1'b1;
                div_num   = nrbf_pkg::DIV_NW'(p_reg)
                          + nrbf_pkg::DIV_NW'({den_reg, 11'b0});
                div_den   = nrbf_pkg::DIV_DW'({den_reg, 12'b0});
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    assign emul    = sum_reg * EXP_M1;
    assign phi_sum = sum_reg + 31'd8192;
    assign x_abs   = x_reg[15] ? 16'(-x_reg) : 16'(x_reg);
    assign num_neg = -num_reg;
    assign num_abs = num_reg[nrbf_pkg::NUM_W-1] ? num_neg[34:0] : num_reg[34:0];
    assign res_neg = x_reg[15] ^ num_reg[nrbf_pkg::NUM_W-1];
    assign r17     = (div_ovf || (div_q > 32'd65536)) ? 17'd65536 : div_q[16:0];
    assign r17_neg = 17'd0 - r17;

    always_comb
    begin
        y_sts = nrbf_pkg::STS_OK;
        if (!res_neg)
        begin
            if (r17 > 17'd32767)
            begin
                y_val = 16'sh7fff;
                y_sts = nrbf_pkg::STS_SAT;
            end
            else
                y_val = signed'(r17[15:0]);
        end
        else
        begin
            if (r17 > 17'd32768)
            begin
                y_val = -16'sh8000;
                y_sts = nrbf_pkg::STS_SAT;
            end
            else
                y_val = signed'(r17_neg[15:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int m = 0; m < N; m++)
            begin
                ctr_reg[m] <= '0;
                wt_reg[m]  <= '0;
            end
            mask_reg <= '0;
            l_reg    <= nrbf_pkg::L_RESET;
        end
        else
        begin
            if (cfg_we)
                l_reg <= cfg_wdata;
            if (cmd.op == nrbf_pkg::DP_ACCEPT && 32'(entry_index) < N)
            begin
                if (op == nrbf_pkg::OP_LOAD_CENTER)
                    ctr_reg[entry_index[IW-1:0]] <= operand_value;
                if (op == nrbf_pkg::OP_LOAD_WEIGHT)
                begin
                    wt_reg[entry_index[IW-1:0]]   <= operand_value;
                    mask_reg[entry_index[IW-1:0]] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            nrbf_pkg::DP_ACCEPT:
            begin
                x_reg <= operand_value;
            end
            nrbf_pkg::DP_ERR:
            begin
                res_val_reg <= '0;
                res_sts_reg <= cmd.code;
            end
            nrbf_pkg::DP_INIT:
            begin
                i_reg   <= '0;
                num_reg <= '0;
                den_reg <= '0;
            end
            nrbf_pkg::DP_RD_CJ:
            begin
                cj_reg <= rd_c;
            end
            nrbf_pkg::DP_D2:
            begin
                d2_reg <= sq[31:0];
            end
            nrbf_pkg::DP_DX2:
            begin
                dx2_reg <= sq[31:0];
            end
            nrbf_pkg::DP_MUL_L:
            begin
                en_reg <= l_reg * dx2_reg;
            end
            nrbf_pkg::DP_DIVE_WAIT:
            begin
                if (div_done)
                begin
                    n_reg    <= div_q[19:16];
                    f_reg    <= div_q[15:0];
                    cnt_reg  <= '0;
                    k_reg    <= 4'd1;
                    term_reg <= nrbf_pkg::ONE_Q30;
                    sum_reg  <= e_big ? 31'd0 : nrbf_pkg::ONE_Q30;
                end
            end
            nrbf_pkg::DP_TMUL:
            begin
                tf_reg <= term_reg * f_reg;
            end
            nrbf_pkg::DP_TDIV_WAIT:
            begin
                if (div_done)
                begin
                    term_reg <= div_q[30:0];
                    sum_reg  <= k_reg[0] ? (sum_reg - div_q[30:0])
                                         : (sum_reg + div_q[30:0]);
                    k_reg    <= k_reg + 1'b1;
                end
            end
            nrbf_pkg::DP_EMUL:
            begin
                if (cnt_reg != n_reg)
                begin
                    sum_reg <= 31'(emul[59:30]);
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
            nrbf_pkg::DP_PHI:
            begin
                phi_reg <= phi_sum[30:14];
            end
            nrbf_pkg::DP_WMUL:
            begin
                pw_reg <= signed'({1'b0, phi_reg}) * wt_reg[i_reg];
            end
            nrbf_pkg::DP_ACC:
            begin
                num_reg <= num_reg + nrbf_pkg::NUM_W'(pw_reg);
                den_reg <= den_reg + nrbf_pkg::DEN_W'(phi_reg);
                i_reg   <= i_reg + 1'b1;
            end
            nrbf_pkg::DP_ABSMUL:
            begin
                p_reg <= x_abs * num_abs;
            end
            nrbf_pkg::DP_FDIV_WAIT:
            begin
                if (div_done)
                begin
                    res_val_reg <= y_val;
                    res_sts_reg <= y_sts;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign stat.mask_full  = &mask_reg;
    assign stat.eq_centers = eq_any;
    assign stat.div_done   = div_done;
    assign stat.e_big      = e_big;
    assign stat.k_last     = (k_reg == nrbf_pkg::TAYLOR_LAST);
    assign stat.n_done     = (cnt_reg == n_reg);
    assign stat.i_last     = (i_reg == IW'(N - 1));
    assign stat.den_zero   = (den_reg == '0);

    assign approx_value = res_val_reg;
    assign status       = res_sts_reg;

endmodule

// ===== rtl/nrbf_ctrl.sv =====
// Controller state machine sequencing the datapath.
module nrbf_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [1:0]          op,
    input  nrbf_pkg::dp_stat_t stat,
    output nrbf_pkg::dp_cmd_t  cmd,
    output logic                busy,
    output logic                done
);

    nrbf_pkg::ctrl_state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            nrbf_pkg::S_IDLE:
                if (start && op == nrbf_pkg::OP_EVAL)
                    state_next = nrbf_pkg::S_CHECK;
            nrbf_pkg::S_CHECK:
                if (!stat.mask_full || stat.eq_centers)
                    state_next = nrbf_pkg::S_DONE;
                else
                    state_next = nrbf_pkg::S_RD_CJ;
            nrbf_pkg::S_RD_CJ:   state_next = nrbf_pkg::S_D2;
            nrbf_pkg::S_D2:      state_next = nrbf_pkg::S_DX2;
            nrbf_pkg::S_DX2:     state_next = nrbf_pkg::S_MUL_L;
            nrbf_pkg::S_MUL_L:   state_next = nrbf_pkg::S_DIVE_GO;
            nrbf_pkg::S_DIVE_GO: state_next = nrbf_pkg::S_DIVE_WAIT;
            nrbf_pkg::S_DIVE_WAIT:
                if (stat.div_done)
                    state_next = stat.e_big ? nrbf_pkg::S_PHI : nrbf_pkg::S_TMUL;
            nrbf_pkg::S_TMUL:    state_next = nrbf_pkg::S_TDIV_GO;
            nrbf_pkg::S_TDIV_GO: state_next = nrbf_pkg::S_TDIV_WAIT;
            nrbf_pkg::S_TDIV_WAIT:
                if (stat.div_done)
                    state_next = stat.k_last ? nrbf_pkg::S_EMUL : nrbf_pkg::S_TMUL;
            nrbf_pkg::S_EMUL:
                if (stat.n_done)
                    state_next = nrbf_pkg::S_PHI;
            nrbf_pkg::S_PHI:     state_next = nrbf_pkg::S_WMUL;
            nrbf_pkg::S_WMUL:    state_next = nrbf_pkg::S_ACC;
            nrbf_pkg::S_ACC:
                state_next = stat.i_last ? nrbf_pkg::S_FIN : nrbf_pkg::S_RD_CJ;
            nrbf_pkg::S_FIN:
                state_next = stat.den_zero ? nrbf_pkg::S_DONE : nrbf_pkg::S_ABSMUL;
            nrbf_pkg::S_ABSMUL:  state_next = nrbf_pkg::S_FDIV_GO;
            nrbf_pkg::S_FDIV_GO: state_next = nrbf_pkg::S_FDIV_WAIT;
            nrbf_pkg::S_FDIV_WAIT:
                if (stat.div_done)
                    state_next = nrbf_pkg::S_DONE;
            nrbf_pkg::S_DONE:    state_next = nrbf_pkg::S_IDLE;
            default:             state_next = nrbf_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.op   = nrbf_pkg::DP_NOP;
        cmd.code = nrbf_pkg::STS_OK;
        unique case (state_reg)
            nrbf_pkg::S_IDLE:
                if (start)
                    cmd.op = nrbf_pkg::DP_ACCEPT;
            nrbf_pkg::S_CHECK:
                if (!stat.mask_full)
                begin
                    cmd.op   = nrbf_pkg::DP_ERR;
                    cmd.code = nrbf_pkg::STS_NO_WEIGHT;
                end
                else if (stat.eq_centers)
                begin
                    cmd.op   = nrbf_pkg::DP_ERR;
                    cmd.code = nrbf_pkg::STS_EQ_CENTER;
                end
                else
                    cmd.op = nrbf_pkg::DP_INIT;
            nrbf_pkg::S_RD_CJ:     cmd.op = nrbf_pkg::DP_RD_CJ;
            nrbf_pkg::S_D2:        cmd.op = nrbf_pkg::DP_D2;
            nrbf_pkg::S_DX2:       cmd.op = nrbf_pkg::DP_DX2;
            nrbf_pkg::S_MUL_L:     cmd.op = nrbf_pkg::DP_MUL_L;
            nrbf_pkg::S_DIVE_GO:   cmd.op = nrbf_pkg::DP_DIVE_GO;
            nrbf_pkg::S_DIVE_WAIT: cmd.op = nrbf_pkg::DP_DIVE_WAIT;
            nrbf_pkg::S_TMUL:      cmd.op = nrbf_pkg::DP_TMUL;
            nrbf_pkg::S_TDIV_GO:   cmd.op = nrbf_pkg::DP_TDIV_GO;
            nrbf_pkg::S_TDIV_WAIT: cmd.op = nrbf_pkg::DP_TDIV_WAIT;
            nrbf_pkg::S_EMUL:      cmd.op = nrbf_pkg::DP_EMUL;
            nrbf_pkg::S_PHI:       cmd.op = nrbf_pkg::DP_PHI;
            nrbf_pkg::S_WMUL:      cmd.op = nrbf_pkg::DP_WMUL;
            nrbf_pkg::S_ACC:       cmd.op = nrbf_pkg::DP_ACC;
            nrbf_pkg::S_FIN:
                if (stat.den_zero)
                begin
                    cmd.op   = nrbf_pkg::DP_ERR;
                    cmd.code = nrbf_pkg::STS_ZERO_SUM;
                end
            nrbf_pkg::S_ABSMUL:    cmd.op = nrbf_pkg::DP_ABSMUL;
            nrbf_pkg::S_FDIV_GO:   cmd.op = nrbf_pkg::DP_FDIV_GO;
            nrbf_pkg::S_FDIV_WAIT: cmd.op = nrbf_pkg::DP_FDIV_WAIT;
            default:               cmd.op = nrbf_pkg::DP_NOP;
        endcase
    end

    assign busy = (state_reg != nrbf_pkg::S_IDLE);
    assign done = (state_reg == nrbf_pkg::S_DONE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= nrbf_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== tb/normalized_rbf_evaluator_core_test.sv =====
// Self-checking testbench for the normalized RBF evaluator core.
`timescale 1ns / 1ps

module normalized_rbf_evaluator_core_test;

    localparam logic [1:0] OP_UNDEFINED = 2'd3;

    typedef struct packed {
        logic [1:0]         op;
        logic [2:0]         idx;
        logic signed [15:0] val;
    } beat_t;

    typedef struct packed {
        logic signed [15:0] value;
        logic [2:0]         sts;
    } rbf_result_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         op;
    logic [2:0]         entry_index;
    logic signed [15:0] operand_value;
    logic               cfg_we;
    logic [15:0]        cfg_wdata;
    logic               done;
    logic signed [15:0] approx_value;
    logic [2:0]         status;

    normalized_rbf_evaluator_core DUT
    (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .op(op),
        .entry_index(entry_index),
        .operand_value(operand_value),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .done(done),
        .approx_value(approx_value),
        .status(status)
    );

    beat_t       pending_beats[$];
    rbf_result_t expected_results[$];
    int          errors = 0;
    int          quiet_cycles = 0;
    int          gap_left = 0;
    bit          gaps_on = 1;
    bit          flushing = 0;

    logic signed [15:0] centers[nrbf_pkg::NUM_CENTERS];
    logic signed [15:0] weights[nrbf_pkg::NUM_CENTERS];
    logic [nrbf_pkg::NUM_CENTERS-1:0] weight_mask;
    logic [15:0] overlap;

    function automatic logic [63:0] exp_frac_q30(logic [63:0] f);
        logic [63:0] term;
        logic [63:0] acc;
        term = 64'd1 << 30;
        acc = term;
        for (int k = 1; k <= 13; k++)
        begin
            term = (term * f) / (64'(k) << 16);
            if (k % 2 == 1)
                acc = acc - term;
            else
                acc = acc + term;
        end
        return acc;
    endfunction

    function automatic logic [63:0] gauss_q16(logic [63:0] e);
        logic [63:0] v;
        logic [63:0] e1;
        if (e >= (64'd16 << 16))
            return 0;
        v = exp_frac_q30(e & 64'hFFFF);
        e1 = exp_frac_q30(64'd1 << 16);
        for (int i = 0; i < int'(e >> 16); i++)
            v = (v * e1) >> 30;
        return (v + (64'd1 << 13)) >> 14;
    endfunction

    function automatic void apply_beat(beat_t b);
        rbf_result_t r;
        longint num;
        longint den;
        longint d;
        longint dx;
        longint ph;
        longint y;
        logic [63:0] e;
        logic [63:0] p;
        logic [63:0] q;
        logic [63:0] mag;
        int j;
        num = 0;
        den = 0;
        if (b.op == nrbf_pkg::OP_LOAD_CENTER || b.op == nrbf_pkg::OP_LOAD_WEIGHT)
        begin
            if (b.idx < nrbf_pkg::NUM_CENTERS)
            begin
                if (b.op == nrbf_pkg::OP_LOAD_CENTER)
                    centers[b.idx] = b.val;
                else
                begin
                    weights[b.idx] = b.val;
                    weight_mask[b.idx] = 1'b1;
                end
            end
            return;
        end
        if (b.op != nrbf_pkg::OP_EVAL)
            return;
        r.value = 0;
        if (!(&weight_mask))
        begin
            r.sts = nrbf_pkg::STS_NO_WEIGHT;
            expected_results.push_back(r);
            return;
        end
        for (int i = 1; i < nrbf_pkg::NUM_CENTERS; i++)
            if (centers[i] == centers[i-1])
            begin
                r.sts = nrbf_pkg::STS_EQ_CENTER;
                expected_results.push_back(r);
                return;
            end
        for (int i = 0; i < nrbf_pkg::NUM_CENTERS; i++)
        begin
            j = (i < nrbf_pkg::NUM_CENTERS - 1) ? i : nrbf_pkg::NUM_CENTERS - 2;
            d = longint'(centers[j+1]) - longint'(centers[j]);
            dx = longint'(b.val) - longint'(centers[i]);
            e = (64'(overlap) * 64'(dx * dx) * 64'd16) / 64'(d * d);
            ph = longint'(gauss_q16(e));
            num += ph * longint'(weights[i]);
            den += ph;
        end
        if (den == 0)
        begin
            r.sts = nrbf_pkg::STS_ZERO_SUM;
            expected_results.push_back(r);
            return;
        end
        p = 64'(b.val < 0 ? -longint'(b.val) : longint'(b.val)) * 64'(num < 0 ? -num : num);
        q = 64'(den) << 12;
        mag = (p + q / 2) / q;
        if (mag > 65536)
            mag = 65536;
        y = ((b.val < 0) != (num < 0)) ? -longint'(mag) : longint'(mag);
        r.sts = nrbf_pkg::STS_OK;
        if (y > 32767)
        begin
            y = 32767;
            r.sts = nrbf_pkg::STS_SAT;
        end
        if (y < -32768)
        begin
            y = -32768;
            r.sts = nrbf_pkg::STS_SAT;
        end
        r.value = y[15:0];
        expected_results.push_back(r);
    endfunction

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // driver
    always @(posedge clk)
    begin
        if (start && !busy && rst_n)
            apply_beat('{op, entry_index, operand_value});
        if (start && busy)
        begin
        end
        else if (gap_left > 0)
        begin
            gap_left <= gap_left - 1;
            start <= 1'b0;
        end
        else if (pending_beats.size() > 0 && rst_n && !flushing
                 && !(start && !busy && pending_beats.size() == 0))
        begin
            if (gaps_on && $urandom_range(0, 5) == 0)
            begin
                gap_left <= $urandom_range(0, 2);
                start <= 1'b0;
            end
            else
            begin
                beat_t b;
                b = pending_beats.pop_front();
                start <= 1'b1;
                op <= b.op;
                entry_index <= b.idx;
                operand_value <= b.val;
            end
        end
        else
            start <= 1'b0;
    end

    // monitor and watchdog
    always @(posedge clk)
    begin
        if (done)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result value=%0d status=%0d", approx_value, status);
                errors++;
            end
            else
            begin
                rbf_result_t x;
                x = expected_results.pop_front();
                if (approx_value !== x.value)
                begin
                    $error("approx_value expected %0d actual %0d", x.value, approx_value);
                    errors++;
                end
                if (status !== x.sts)
                begin
                    $error("status expected %0d actual %0d", x.sts, status);
                    errors++;
                end
            end
        end
        if (done || (start && !busy))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 40000)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic push(logic [1:0] o, logic [2:0] i, logic signed [15:0] v);
        pending_beats.push_back('{o, i, v});
    endtask

    task automatic drain();
        flushing = 0;
        wait (pending_beats.size() == 0);
        @(posedge clk);
        @(posedge clk);
        while (busy || start || expected_results.size() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_overlap(logic [15:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        overlap = v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_grid(int spacing, int base);
        for (int i = 0; i < nrbf_pkg::NUM_CENTERS; i++)
            push(nrbf_pkg::OP_LOAD_CENTER, 3'(i), 16'(base + i * spacing));
    endtask

    task automatic random_phase(int n);
        int s;
        for (int k = 0; k < n; k++)
        begin
            s = $urandom_range(0, 19);
            if (s == 0)
                push(OP_UNDEFINED, 3'($urandom), 16'($urandom));
            else if (s < 3)
                push(nrbf_pkg::OP_LOAD_WEIGHT, 3'($urandom), 16'($urandom));
            else if (s < 4)
                push(nrbf_pkg::OP_LOAD_CENTER, 3'($urandom), 16'($urandom));
            else if (s < 6)
                push(nrbf_pkg::OP_EVAL, 3'd0, 16'($urandom));
            else
                push(nrbf_pkg::OP_EVAL, 3'd0,
                     16'($signed(16'($urandom_range(0, 4096))) - 16'sd2048));
        end
    endtask

    initial
    begin
        rst_n = 0;
        start = 0;
        op = 0;
        entry_index = 0;
        operand_value = 0;
        cfg_we = 0;
        cfg_wdata = 0;
        overlap = nrbf_pkg::L_RESET;
        weight_mask = 0;
        for (int i = 0; i < nrbf_pkg::NUM_CENTERS; i++)
        begin
            centers[i] = 0;
            weights[i] = 0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        // directed: missing weights, equal centers, extremes
        push(nrbf_pkg::OP_EVAL, 3'd0, 16'sh0100);
        for (int i = 0; i < nrbf_pkg::NUM_CENTERS; i++)
            push(nrbf_pkg::OP_LOAD_WEIGHT, 3'(i), (i % 2) ? 16'sh7FFF : 16'sh8000);
        push(nrbf_pkg::OP_EVAL, 3'd7, 16'sh0000);
        load_grid(256, -1024);
        push(nrbf_pkg::OP_EVAL, 3'd0, 16'sh7FFF);
        push(nrbf_pkg::OP_EVAL, 3'd0, 16'sh8000);
        push(nrbf_pkg::OP_EVAL, 3'd0, 16'sh0080);
        push(OP_UNDEFINED, 3'd5, 16'shFFFF);
        push(nrbf_pkg::OP_LOAD_WEIGHT, 3'd2, 16'sh1000);
        push(nrbf_pkg::OP_EVAL, 3'd0, 16'shFF00);
        drain();
        write_overlap(16'hFFFF);
        load_grid(1, 0);
        push(nrbf_pkg::OP_EVAL, 3'd0, 16'sh4000);
        push(nrbf_pkg::OP_EVAL, 3'd0, 16'sh0003);
        drain();
        write_overlap(16'h0000);
        push(nrbf_pkg::OP_EVAL, 3'd0, 16'sh7FFF);
        load_grid(-4096, 16000);
        push(nrbf_pkg::OP_EVAL, 3'd0, 16'sh8000);
        drain();
        for (int ph = 0; ph < 6; ph++)
        begin
            write_overlap(ph == 5 ? nrbf_pkg::L_RESET : 16'($urandom_range(0, 12000)));
            load_grid(int'($urandom_range(16, 600)), -int'($urandom_range(0, 2048)));
            for (int i = 0; i < nrbf_pkg::NUM_CENTERS; i++)
                push(nrbf_pkg::OP_LOAD_WEIGHT, 3'(i), 16'($urandom));
            if (ph == 5)
                gaps_on = 0;
            random_phase(85);
            drain();
        end
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
